/* design/tdvl_pkg.sv */
// Package for the triangle diffuse vertex lighting block: widths, types and register indexes.
// Used by every module of the block; depends on nothing.
package tdvl_pkg;

    localparam int COORD_W   = 24;
    localparam int FRAC_BITS = 8;
    localparam int K_W       = 8;

    localparam int DIFF_W = COORD_W + 1;
    localparam int PROD_W = 2 * DIFF_W;
    localparam int NRM_W  = PROD_W + 1;
    localparam int LL_W   = PROD_W + 2;
    localparam int NN_W   = 2 * NRM_W + 2;
    localparam int PD_W   = DIFF_W + NRM_W + 1;
    localparam int D_W    = PD_W + 1;
    localparam int M_W    = LL_W + NN_W;
    localparam int DD_W   = 2 * (D_W - 1);
    localparam int T1_W   = DD_W + K_W;
    localparam int T_W    = DD_W + 2 * K_W;
    localparam int ACC_W  = T_W + 4;

    localparam int CHUNK_W = 26;
    localparam int MUL_AN  = 3;
    localparam int MUL_BN  = 4;
    localparam int MUL_A_W = CHUNK_W * MUL_AN;
    localparam int MUL_B_W = CHUNK_W * MUL_BN;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    localparam int FRONT_LAT = 13;
    localparam int LANE_LAT  = FRONT_LAT + K_W;

    localparam int TDATA_IN_W  = 9 * COORD_W;
    localparam int TDATA_OUT_W = 3 * K_W;
    localparam int CFG_IDX_W   = 2;

    localparam logic [CFG_IDX_W-1:0] REG_LIGHT_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LIGHT_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LIGHT_Z = 2'd2;

    localparam logic [COORD_W-1:0] LIGHT_Y_RST = COORD_W'(45 << FRAC_BITS);

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [DIFF_W-1:0]  t_diff;
    typedef logic signed [PROD_W-1:0]  t_prod;
    typedef logic signed [NRM_W-1:0]   t_nrm;

endpackage

/* design/triangle_diffuse_vertex_lighting.sv */
// Top level of the triangle diffuse vertex lighting block: ports, light registers, lanes, output.
// Depends on tdvl_pkg, tdvl_normal and tdvl_lane.
//
//   channel   direction  handshake                word
//   s         in         i_s_tvalid / o_s_tready  one triangle, 216-bit i_s_tdata
//   m         out        o_m_tvalid / i_m_tready  three intensities, 24-bit o_m_tdata
//   cfg       in         i_cfg_we                 light_x, light_y, light_z
//
// One triangle per cycle while the output is not stalled; each word passes the 13-stage
// geometry front, the 8-stage intensity search in each vertex lane and the output register.
// Reset clears the pipeline valid bits and the output valid; the light takes 0, 45.0, 0.
// A stalled output word holds the whole pipeline; input is taken whenever the
// output register is empty or being emptied.
module triangle_diffuse_vertex_lighting (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    // ax, ay, az, bx, by, bz, cx, cy, cz from the lowest bit up
    input  logic [tdvl_pkg::TDATA_IN_W-1:0]     i_s_tdata,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // intensity_a, intensity_b, intensity_c from the lowest bit up
    output logic [tdvl_pkg::TDATA_OUT_W-1:0]    o_m_tdata,
    input  logic                                i_cfg_we,
    input  logic [tdvl_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [tdvl_pkg::COORD_W-1:0]        i_cfg_data
);
    localparam int CW  = tdvl_pkg::COORD_W;
    localparam int LAT = tdvl_pkg::LANE_LAT;
    localparam int KW  = tdvl_pkg::K_W;

    tdvl_pkg::t_coord r_light [3];
    tdvl_pkg::t_coord w_a [3];
    tdvl_pkg::t_coord w_b [3];
    tdvl_pkg::t_coord w_c [3];
    tdvl_pkg::t_nrm   w_n [3];
    logic [tdvl_pkg::NN_W-1:0] w_nn;
    logic [KW-1:0]    w_ka;
    logic [KW-1:0]    w_kb;
    logic [KW-1:0]    w_kc;
    logic             w_en;
    logic [LAT-1:0]   r_vld;
    logic             r_ovld;
    logic [tdvl_pkg::TDATA_OUT_W-1:0] r_odata;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_a[i] = i_s_tdata[i*CW +: CW];
            w_b[i] = i_s_tdata[(3+i)*CW +: CW];
            w_c[i] = i_s_tdata[(6+i)*CW +: CW];
        end
    end

    assign w_en = !r_ovld || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld      <= '0;
            r_ovld     <= 1'b0;
            r_light[0] <= '0;
            r_light[1] <= tdvl_pkg::LIGHT_Y_RST;
            r_light[2] <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    tdvl_pkg::REG_LIGHT_X: r_light[0] <= i_cfg_data;
                    tdvl_pkg::REG_LIGHT_Y: r_light[1] <= i_cfg_data;
                    tdvl_pkg::REG_LIGHT_Z: r_light[2] <= i_cfg_data;
                    default: ;
                endcase
            end
            if (w_en) begin
                r_vld  <= {r_vld[LAT-2:0], i_s_tvalid};
                r_ovld <= r_vld[LAT-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_odata <= {w_kc, w_kb, w_ka};
        end
    end

    tdvl_normal u_normal (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_a   (w_a),
        .i_b   (w_b),
        .i_c   (w_c),
        .o_n   (w_n),
        .o_nn  (w_nn)
    );

    tdvl_lane u_lane_a (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_light (r_light),
        .i_p     (w_a),
        .i_n     (w_n),
        .i_nn    (w_nn),
        .o_k     (w_ka)
    );

    tdvl_lane u_lane_b (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_light (r_light),
        .i_p     (w_b),
        .i_n     (w_n),
        .i_nn    (w_nn),
        .o_k     (w_kb)
    );

    tdvl_lane u_lane_c (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_light (r_light),
        .i_p     (w_c),
        .i_n     (w_n),
        .i_nn    (w_nn),
        .o_k     (w_kc)
    );

    assign o_s_tready = w_en;
    assign o_m_tvalid = r_ovld;
    assign o_m_tdata  = r_odata;

endmodule

/* design/tdvl_mul.sv */
// Pipelined unsigned multiplier, split into chunk partial products over three stages.
// Depends on tdvl_pkg for the operand and chunk widths.
module tdvl_mul (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [tdvl_pkg::MUL_A_W-1:0]  i_a,
    input  logic [tdvl_pkg::MUL_B_W-1:0]  i_b,
    output logic [tdvl_pkg::MUL_P_W-1:0]  o_p
);
    localparam int CW    = tdvl_pkg::CHUNK_W;
    localparam int AN    = tdvl_pkg::MUL_AN;
    localparam int BN    = tdvl_pkg::MUL_BN;
    localparam int ROW_W = tdvl_pkg::MUL_B_W + CW;
    localparam int PW    = tdvl_pkg::MUL_P_W;

    logic [2*CW-1:0]  r_pp  [AN][BN];
    logic [ROW_W-1:0] r_row [AN];
    logic [ROW_W-1:0] n_row [AN];
    logic [PW-1:0]    r_p;
    logic [PW-1:0]    n_p;

    always_comb begin
        for (int i = 0; i < AN; i++) begin
            n_row[i] = '0;
            for (int j = 0; j < BN; j++) begin
                n_row[i] = n_row[i] + (ROW_W'(r_pp[i][j]) << (j * CW));
            end
        end
        n_p = '0;
        for (int i = 0; i < AN; i++) begin
            n_p = n_p + (PW'(r_row[i]) << (i * CW));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < AN; i++) begin
                for (int j = 0; j < BN; j++) begin
                    r_pp[i][j] <= (2*CW)'(i_a[i*CW +: CW]) * (2*CW)'(i_b[j*CW +: CW]);
                end
            end
            r_row <= n_row;
            r_p   <= n_p;
        end
    end

    assign o_p = r_p;

endmodule

/* design/tdvl_normal.sv */
// Face normal n = (B-A) x (C-A) and its squared length, shared by the three lanes.
// Depends on tdvl_pkg and tdvl_mul.
module tdvl_normal (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  tdvl_pkg::t_coord           i_a [3],
    input  tdvl_pkg::t_coord           i_b [3],
    input  tdvl_pkg::t_coord           i_c [3],
    output tdvl_pkg::t_nrm             o_n [3],
    output logic [tdvl_pkg::NN_W-1:0]  o_nn
);
    localparam int DW = tdvl_pkg::DIFF_W;
    localparam int PW = tdvl_pkg::PROD_W;
    localparam int NW = tdvl_pkg::NRM_W;
    localparam int QW = tdvl_pkg::NN_W;

    tdvl_pkg::t_diff r_ab [3];
    tdvl_pkg::t_diff r_ac [3];
    tdvl_pkg::t_prod r_p1 [3];
    tdvl_pkg::t_prod r_p2 [3];
    tdvl_pkg::t_nrm  r_n  [3];
    logic [NW-1:0]   w_na [3];
    logic [tdvl_pkg::MUL_P_W-1:0] w_sq [3];
    logic [QW-1:0]   r_nn;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_ab[i] <= DW'(i_b[i]) - DW'(i_a[i]);
                r_ac[i] <= DW'(i_c[i]) - DW'(i_a[i]);
                r_n[i]  <= NW'(r_p1[i]) - NW'(r_p2[i]);
            end
            r_nn <= QW'(w_sq[0][2*NW-1:0]) + QW'(w_sq[1][2*NW-1:0])
                  + QW'(w_sq[2][2*NW-1:0]);
        end
    end

    for (genvar i = 0; i < 3; i++) begin : g_axis
        localparam int J = (i + 1) % 3;
        localparam int K = (i + 2) % 3;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_p1[i] <= PW'(r_ab[J]) * PW'(r_ac[K]);
                r_p2[i] <= PW'(r_ab[K]) * PW'(r_ac[J]);
            end
        end

        assign w_na[i] = r_n[i][NW-1] ? NW'(-r_n[i]) : NW'(r_n[i]);

        tdvl_mul u_sq (
            .i_clk (i_clk),
            .i_en  (i_en),
            .i_a   (tdvl_pkg::MUL_A_W'(w_na[i])),
            .i_b   (tdvl_pkg::MUL_B_W'(w_na[i])),
            .o_p   (w_sq[i])
        );
    end

    assign o_n  = r_n;
    assign o_nn = r_nn;

endmodule

/* design/tdvl_lane.sv */
// One vertex lane: light vector, dot product, squared terms and the 8-bit intensity search.
// Depends on tdvl_pkg and tdvl_mul; fed with the normal from tdvl_normal.
module tdvl_lane (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  tdvl_pkg::t_coord           i_light [3],
    input  tdvl_pkg::t_coord           i_p [3],
    input  tdvl_pkg::t_nrm             i_n [3],
    input  logic [tdvl_pkg::NN_W-1:0]  i_nn,
    output logic [tdvl_pkg::K_W-1:0]   o_k
);
    localparam int DW = tdvl_pkg::DIFF_W;
    localparam int PW = tdvl_pkg::PROD_W;
    localparam int NW = tdvl_pkg::NRM_W;
    localparam int LW = tdvl_pkg::LL_W;
    localparam int QW = tdvl_pkg::NN_W;
    localparam int XW = tdvl_pkg::PD_W;
    localparam int EW = tdvl_pkg::D_W;
    localparam int MW = tdvl_pkg::M_W;
    localparam int SW = tdvl_pkg::DD_W;
    localparam int UW = tdvl_pkg::T1_W;
    localparam int TW = tdvl_pkg::T_W;
    localparam int AW = tdvl_pkg::ACC_W;
    localparam int KW = tdvl_pkg::K_W;
    localparam int BW = tdvl_pkg::MUL_B_W;
    localparam int IW = tdvl_pkg::MUL_A_W;
    localparam int PRW = tdvl_pkg::MUL_P_W;

    tdvl_pkg::t_diff r_l1  [3];
    tdvl_pkg::t_diff r_l2  [3];
    tdvl_pkg::t_diff r_l3  [3];
    tdvl_pkg::t_prod r_lsq [3];
    logic [LW-1:0]   r_ll;
    logic [LW-1:0]   r_lld [5];
    logic [DW-1:0]   w_la  [3];
    logic [NW-1:0]   w_nb  [3];
    logic [2:0]      w_sg;
    logic [2:0]      r_sg  [3];
    logic [PRW-1:0]  w_ldp [3];
    logic signed [XW-1:0] r_pd [3];
    logic signed [EW-1:0] r_d;
    logic [QW-1:0]   r_nn8;
    logic            w_dpos;
    logic [EW-2:0]   w_dmag;
    logic            w_z;
    logic [4:0]      r_z;
    logic [PRW-1:0]  w_mp;
    logic [PRW-1:0]  w_ddp;
    logic [UW-1:0]   r_t1;
    logic [TW-1:0]   r_t;
    logic [MW-1:0]   r_m12;
    logic [MW-1:0]   r_m13;

    logic [KW-1:0]   w_ik   [KW];
    logic [AW-1:0]   w_ik2m [KW];
    logic [AW-1:0]   w_ikm  [KW];
    logic [MW-1:0]   w_im   [KW];
    logic [TW-1:0]   w_it   [KW];
    logic            w_iz   [KW];
    logic [KW-1:0]   r_sk   [KW];
    logic [AW-1:0]   r_sk2m [KW];
    logic [AW-1:0]   r_skm  [KW];
    logic [MW-1:0]   r_sm   [KW];
    logic [TW-1:0]   r_st   [KW];
    logic            r_sz   [KW];

    for (genvar i = 0; i < 3; i++) begin : g_axis
        assign w_la[i] = r_l3[i][DW-1] ? DW'(-r_l3[i]) : DW'(r_l3[i]);
        assign w_nb[i] = i_n[i][NW-1] ? NW'(-i_n[i]) : NW'(i_n[i]);
        assign w_sg[i] = r_l3[i][DW-1] ^ i_n[i][NW-1];

        tdvl_mul u_dot (
            .i_clk (i_clk),
            .i_en  (i_en),
            .i_a   (IW'(w_la[i])),
            .i_b   (BW'(w_nb[i])),
            .o_p   (w_ldp[i])
        );
    end

    assign w_dpos = !r_d[EW-1] && (r_d != '0);
    assign w_dmag = w_dpos ? r_d[EW-2:0] : '0;
    assign w_z    = !w_dpos || (r_lld[4] == '0) || (r_nn8 == '0);

    tdvl_mul u_m (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_a   (IW'(r_lld[4])),
        .i_b   (BW'(r_nn8)),
        .o_p   (w_mp)
    );

    tdvl_mul u_dd (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_a   (IW'(w_dmag)),
        .i_b   (BW'(w_dmag)),
        .o_p   (w_ddp)
    );

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_l1[i]  <= DW'(i_light[i]) - DW'(i_p[i]);
                r_lsq[i] <= PW'(r_l1[i]) * PW'(r_l1[i]);
                r_l2[i]  <= r_l1[i];
                r_l3[i]  <= r_l2[i];
                r_pd[i]  <= r_sg[2][i] ? -XW'(w_ldp[i][XW-2:0]) : XW'(w_ldp[i][XW-2:0]);
            end
            r_ll     <= LW'($unsigned(r_lsq[0])) + LW'($unsigned(r_lsq[1]))
                      + LW'($unsigned(r_lsq[2]));
            r_lld[0] <= r_ll;
            for (int s = 1; s < 5; s++) begin
                r_lld[s] <= r_lld[s-1];
            end
            r_sg[0]  <= w_sg;
            r_sg[1]  <= r_sg[0];
            r_sg[2]  <= r_sg[1];
            r_d      <= EW'(r_pd[0]) + EW'(r_pd[1]) + EW'(r_pd[2]);
            r_nn8    <= i_nn;
            r_z      <= {r_z[3:0], w_z};
            r_t1     <= (UW'(w_ddp[SW-1:0]) << KW) - UW'(w_ddp[SW-1:0]);
            r_m12    <= w_mp[MW-1:0];
            r_t      <= (TW'(r_t1) << KW) - TW'(r_t1);
            r_m13    <= r_m12;
        end
    end

    for (genvar s = 0; s < KW; s++) begin : g_bit
        localparam int B = KW - 1 - s;
        logic [AW-1:0] w_cand;
        logic          w_take;

        if (s == 0) begin : g_first
            assign w_ik[s]   = '0;
            assign w_ik2m[s] = '0;
            assign w_ikm[s]  = '0;
            assign w_im[s]   = r_m13;
            assign w_it[s]   = r_t;
            assign w_iz[s]   = r_z[4];
        end else begin : g_next
            assign w_ik[s]   = r_sk[s-1];
            assign w_ik2m[s] = r_sk2m[s-1];
            assign w_ikm[s]  = r_skm[s-1];
            assign w_im[s]   = r_sm[s-1];
            assign w_it[s]   = r_st[s-1];
            assign w_iz[s]   = r_sz[s-1];
        end

        assign w_cand = w_ik2m[s] + (w_ikm[s] << (B + 1)) + (AW'(w_im[s]) << (2 * B));
        assign w_take = (w_cand <= AW'(w_it[s]));

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_sk[s]   <= w_take ? (w_ik[s] | KW'(1 << B)) : w_ik[s];
                r_sk2m[s] <= w_take ? w_cand : w_ik2m[s];
                r_skm[s]  <= w_take ? (w_ikm[s] + (AW'(w_im[s]) << B)) : w_ikm[s];
                r_sm[s]   <= w_im[s];
                r_st[s]   <= w_it[s];
                r_sz[s]   <= w_iz[s];
            end
        end
    end

    assign o_k = r_sz[KW-1] ? '0 : r_sk[KW-1];

endmodule

/* design/tdvl_chk.sv */
// Port checker for the triangle diffuse vertex lighting block, bound to the top level.
// Depends on tdvl_pkg for the port widths.
module tdvl_chk (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_s_tvalid,
    input logic                              o_s_tready,
    input logic                              o_m_tvalid,
    input logic                              i_m_tready,
    input logic [tdvl_pkg::TDATA_OUT_W-1:0]  o_m_tdata
);

    a_hold_valid : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> o_m_tvalid)
        else $error("output word dropped while stalled");

    a_hold_data : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> $stable(o_m_tdata))
        else $error("output word changed while stalled");

    a_reset_empty : assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output word present after reset");

    a_ready_rule : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready == (!o_m_tvalid || i_m_tready))
        else $error("input ready does not follow output state");

    a_no_stall_empty : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_m_tvalid && i_s_tvalid) |-> o_s_tready)
        else $error("input refused with empty output");

endmodule

bind triangle_diffuse_vertex_lighting tdvl_chk u_tdvl_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
